@@ rtl/lfurb_pkg.sv @@
// types and constants shared by the line framing ring buffer block
package lfurb_pkg;

    localparam logic [1:0] CMD_RX_BYTE  = 2'd0;
    localparam logic [1:0] CMD_GET_LINE = 2'd1;
    localparam logic [1:0] CMD_TX_READY = 2'd2;
    localparam logic [1:0] CMD_PUSH     = 2'd3;

    localparam logic [1:0] KIND_ACK  = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_TERM = 2'd2;
    localparam logic [1:0] KIND_TX   = 2'd3;

    localparam logic [7:0] BYTE_NUL = 8'd0;
    localparam logic [7:0] BYTE_LF  = 8'd10;
    localparam logic [7:0] BYTE_CR  = 8'd13;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] out_byte;
        logic       last;
        logic       rx_flushed;
        logic       tx_dropped;
        logic [7:0] lines_pending;
    } out_item_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

endpackage

@@ rtl/lfurb_ring.sv @@
// ring buffer with one-slot-free full rule and registered read data
module lfurb_ring #(
    parameter int DEPTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lfurb_pkg::ring_ctrl_t ctrl,
    input  logic [7:0]            wr_data,
    output lfurb_pkg::ring_stat_t stat,
    output logic [7:0]            rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_next;
    logic [AW-1:0] wr_adv;
    logic [AW-1:0] rd_adv;
    logic [7:0]    rd_data_reg;

    assign wr_adv = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_adv = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;

    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (wr_adv == rd_ptr_reg);
    assign rd_data    = rd_data_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (ctrl.flush) begin
            wr_ptr_next = rd_ptr_reg;
        end else if (ctrl.push) begin
            wr_ptr_next = wr_adv;
        end
        if (ctrl.pop) begin
            rd_ptr_next = rd_adv;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push && !ctrl.flush) begin
            mem[wr_adv] <= wr_data;
        end
        if (ctrl.pop) begin
            rd_data_reg <= mem[rd_adv];
        end
    end

endmodule

@@ rtl/line_framing_uart_ring_buffers_unit.sv @@
// top level: receive and transmit rings with line framing sequencer
//
// channel | ports                      | payload
// --------+----------------------------+--------------------------
// input   | s_valid s_ready s_item     | lfurb_pkg::in_item_t
// result  | m_valid m_ready m_item     | lfurb_pkg::out_item_t
//
// received byte and host push: ST_RX or ST_PUSH, then the acknowledge; transmitter
// ready: ST_TXREQ, plus ST_TXOUT for the registered read port when a byte is queued
// get line: no result with no line pending, else ST_LREQ and ST_LCHK per popped byte,
// then ST_LTERM, also from ST_LREQ when the ring runs empty before a carriage return
// reset clears pointers, line count and sequencer; ring contents are not cleared
// input is taken only while the sequencer is idle; a full result register holds it
module line_framing_uart_ring_buffers_unit #(
    parameter int RX_DEPTH = 32,
    parameter int TX_DEPTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lfurb_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lfurb_pkg::out_item_t m_item
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RX    = 8'b0000_0010,
        ST_PUSH  = 8'b0000_0100,
        ST_TXREQ = 8'b0000_1000,
        ST_TXOUT = 8'b0001_0000,
        ST_LREQ  = 8'b0010_0000,
        ST_LCHK  = 8'b0100_0000,
        ST_LTERM = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    lfurb_pkg::in_item_t  in_reg;
    logic [7:0]           line_count_reg, line_count_next;
    logic                 m_valid_reg, m_valid_next;
    lfurb_pkg::out_item_t m_item_reg;
    lfurb_pkg::out_item_t emit_item;
    logic                 emit;
    logic                 out_free;
    logic                 accept;

    lfurb_pkg::ring_ctrl_t rx_ctrl, tx_ctrl;
    lfurb_pkg::ring_stat_t rx_stat, tx_stat;
    logic [7:0]            rx_rd_data, tx_rd_data;

    lfurb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .wr_data (in_reg.data_byte),
        .stat    (rx_stat),
        .rd_data (rx_rd_data)
    );

    lfurb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .wr_data (in_reg.data_byte),
        .stat    (tx_stat),
        .rd_data (tx_rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;

    always_comb begin
        state_next      = state_reg;
        line_count_next = line_count_reg;
        rx_ctrl         = '0;
        tx_ctrl         = '0;
        emit            = 1'b0;
        emit_item       = '0;
        emit_item.out_kind = lfurb_pkg::KIND_ACK;
        emit_item.last     = 1'b1;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_item.cmd)
                        lfurb_pkg::CMD_RX_BYTE:  state_next = ST_RX;
                        lfurb_pkg::CMD_GET_LINE: begin
                            if (line_count_reg != 8'd0) begin
                                state_next = ST_LREQ;
                            end
                        end
                        lfurb_pkg::CMD_TX_READY: state_next = ST_TXREQ;
                        lfurb_pkg::CMD_PUSH:     state_next = ST_PUSH;
                        default:                 state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RX: begin
                if (out_free) begin
                    if (rx_stat.full) begin
                        rx_ctrl.flush = 1'b1;
                        emit_item.rx_flushed = 1'b1;
                    end else if (in_reg.data_byte != lfurb_pkg::BYTE_NUL &&
                                 in_reg.data_byte != lfurb_pkg::BYTE_LF) begin
                        rx_ctrl.push = 1'b1;
                        if (in_reg.data_byte == lfurb_pkg::BYTE_CR) begin
                            line_count_next = line_count_reg + 8'd1;
                        end
                        if (tx_stat.full) begin
                            emit_item.tx_dropped = 1'b1;
                        end else begin
                            tx_ctrl.push = 1'b1;
                        end
                    end
                    emit_item.lines_pending = line_count_next;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    if (tx_stat.full) begin
                        emit_item.tx_dropped = 1'b1;
                    end else begin
                        tx_ctrl.push = 1'b1;
                    end
                    emit_item.lines_pending = line_count_reg;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TXREQ: begin
                if (!tx_stat.empty) begin
                    tx_ctrl.pop = 1'b1;
                    state_next  = ST_TXOUT;
                end else if (out_free) begin
                    emit_item.lines_pending = line_count_reg;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TXOUT: begin
                if (out_free) begin
                    emit_item.out_kind      = lfurb_pkg::KIND_TX;
                    emit_item.out_byte      = tx_rd_data;
                    emit_item.lines_pending = line_count_reg;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LREQ: begin
                if (rx_stat.empty) begin
                    state_next = ST_LTERM;
                end else begin
                    rx_ctrl.pop = 1'b1;
                    state_next  = ST_LCHK;
                end
            end
            ST_LCHK: begin
                if (rx_rd_data == lfurb_pkg::BYTE_CR || rx_rd_data == lfurb_pkg::BYTE_NUL) begin
                    state_next = ST_LTERM;
                end else if (out_free) begin
                    emit_item.out_kind      = lfurb_pkg::KIND_CHAR;
                    emit_item.out_byte      = rx_rd_data;
                    emit_item.last          = 1'b0;
                    emit_item.lines_pending = line_count_reg - 8'd1;
                    emit       = 1'b1;
                    state_next = ST_LREQ;
                end
            end
            ST_LTERM: begin
                if (out_free) begin
                    line_count_next         = line_count_reg - 8'd1;
                    emit_item.out_kind      = lfurb_pkg::KIND_TERM;
                    emit_item.lines_pending = line_count_next;
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            line_count_reg <= 8'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            line_count_reg <= line_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg <= s_item;
        end
        if (emit) begin
            m_item_reg <= emit_item;
        end
    end

endmodule

@@ tb/tb_line_framing_uart_ring_buffers_unit.sv @@
// testbench for the line framing ring buffer unit: queued random items, predicted results
module tb_line_framing_uart_ring_buffers_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_DEPTH = 32;
    localparam int TX_DEPTH = 32;
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int TOTAL_ITEMS = 150;
    localparam int CR_FLOOD_ITEMS = 40;
    localparam int TAIL_CYCLES = 80;
    localparam int MODE_CYCLES = 50;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_ONE_IN_FOUR,
        READY_MOSTLY
    } stall_mode_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    lfurb_pkg::in_item_t  s_item = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    lfurb_pkg::out_item_t m_item;

    lfurb_pkg::in_item_t  pending_items[$];
    lfurb_pkg::out_item_t expected_results[$];
    int        total_items = 0;
    int        accepted_items = 0;
    int        error_count = 0;
    int        burst_left = 1;
    int        gap_left = 0;
    int        mode_cycle = 0;
    stall_mode_t stall_mode = READY_ALWAYS;

    logic [7:0]       rx_ring [RX_DEPTH];
    logic [7:0]       tx_ring [TX_DEPTH];
    logic [RX_AW-1:0] rx_wr_idx = '0;
    logic [RX_AW-1:0] rx_rd_idx = '0;
    logic [TX_AW-1:0] tx_wr_idx = '0;
    logic [TX_AW-1:0] tx_rd_idx = '0;
    logic [7:0]       pending_lines = '0;

    line_framing_uart_ring_buffers_unit #(
        .RX_DEPTH(RX_DEPTH),
        .TX_DEPTH(TX_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_item(s_item),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_item(m_item)
    );

    always #5 aclk = ~aclk;

    function automatic logic [RX_AW-1:0] rx_advance(logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [TX_AW-1:0] tx_advance(logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic tx_ring_push(logic [7:0] value);
        logic [TX_AW-1:0] nxt;
        nxt = tx_advance(tx_wr_idx);
        if (nxt == tx_rd_idx) begin
            return 1'b0;
        end
        tx_ring[nxt] = value;
        tx_wr_idx = nxt;
        return 1'b1;
    endfunction

    function automatic lfurb_pkg::out_item_t make_result(logic [1:0] kind, logic [7:0] value,
                                                         logic fin, logic fl, logic dr);
        lfurb_pkg::out_item_t r;
        r.out_kind = kind;
        r.out_byte = value;
        r.last = fin;
        r.rx_flushed = fl;
        r.tx_dropped = dr;
        r.lines_pending = pending_lines;
        return r;
    endfunction

    task automatic predict_item(lfurb_pkg::in_item_t it);
        logic [RX_AW-1:0] nxt;
        logic             fl;
        logic             dr;
        logic             done;
        logic [7:0]       ch;
        case (it.cmd)
            lfurb_pkg::CMD_RX_BYTE: begin
                nxt = rx_advance(rx_wr_idx);
                fl = 1'b0;
                dr = 1'b0;
                if (nxt == rx_rd_idx) begin
                    rx_wr_idx = rx_rd_idx;
                    fl = 1'b1;
                end else if (it.data_byte != lfurb_pkg::BYTE_NUL &&
                             it.data_byte != lfurb_pkg::BYTE_LF) begin
                    if (it.data_byte == lfurb_pkg::BYTE_CR) begin
                        pending_lines = pending_lines + 8'd1;
                    end
                    rx_ring[nxt] = it.data_byte;
                    rx_wr_idx = nxt;
                    dr = !tx_ring_push(it.data_byte);
                end
                expected_results.push_back(
                    make_result(lfurb_pkg::KIND_ACK, lfurb_pkg::BYTE_NUL, 1'b1, fl, dr));
            end
            lfurb_pkg::CMD_GET_LINE: begin
                if (pending_lines != 8'd0) begin
                    pending_lines = pending_lines - 8'd1;
                    done = 1'b0;
                    while (!done && rx_rd_idx != rx_wr_idx) begin
                        rx_rd_idx = rx_advance(rx_rd_idx);
                        ch = rx_ring[rx_rd_idx];
                        if (ch == lfurb_pkg::BYTE_CR || ch == lfurb_pkg::BYTE_NUL) begin
                            done = 1'b1;
                        end else begin
                            expected_results.push_back(
                                make_result(lfurb_pkg::KIND_CHAR, ch, 1'b0, 1'b0, 1'b0));
                        end
                    end
                    expected_results.push_back(
                        make_result(lfurb_pkg::KIND_TERM, lfurb_pkg::BYTE_NUL, 1'b1, 1'b0, 1'b0));
                end
            end
            lfurb_pkg::CMD_TX_READY: begin
                if (tx_rd_idx != tx_wr_idx) begin
                    tx_rd_idx = tx_advance(tx_rd_idx);
                    expected_results.push_back(
                        make_result(lfurb_pkg::KIND_TX, tx_ring[tx_rd_idx], 1'b1, 1'b0, 1'b0));
                end else begin
                    expected_results.push_back(
                        make_result(lfurb_pkg::KIND_ACK, lfurb_pkg::BYTE_NUL, 1'b1, 1'b0, 1'b0));
                end
            end
            default: begin
                dr = !tx_ring_push(it.data_byte);
                expected_results.push_back(
                    make_result(lfurb_pkg::KIND_ACK, lfurb_pkg::BYTE_NUL, 1'b1, 1'b0, dr));
            end
        endcase
    endtask

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_result(lfurb_pkg::out_item_t got);
        lfurb_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            report_error($sformatf("result %h with no item waiting", got));
            return;
        end
        want = expected_results.pop_front();
        if (got.out_kind !== want.out_kind)
            report_error($sformatf("out_kind %0d, want %0d", got.out_kind, want.out_kind));
        if (got.out_byte !== want.out_byte)
            report_error($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
        if (got.last !== want.last)
            report_error($sformatf("last %b, want %b", got.last, want.last));
        if (got.rx_flushed !== want.rx_flushed)
            report_error($sformatf("rx_flushed %b, want %b", got.rx_flushed, want.rx_flushed));
        if (got.tx_dropped !== want.tx_dropped)
            report_error($sformatf("tx_dropped %b, want %b", got.tx_dropped, want.tx_dropped));
        if (got.lines_pending !== want.lines_pending)
            report_error($sformatf("lines_pending %0d, want %0d",
                                   got.lines_pending, want.lines_pending));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_item(s_item);
                accepted_items++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    s_valid <= 1'b1;
                    s_item <= pending_items.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_item);
            end
            if (mode_cycle == MODE_CYCLES - 1) begin
                mode_cycle = 0;
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            end else begin
                mode_cycle++;
            end
            case (stall_mode)
                READY_ALWAYS:      m_ready <= 1'b1;
                READY_COIN:        m_ready <= 1'($urandom_range(0, 1));
                READY_ONE_IN_FOUR: m_ready <= (mode_cycle % 4 == 0);
                default:           m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic add_item(logic [1:0] cmd, logic [7:0] value);
        lfurb_pkg::in_item_t it;
        it.cmd = cmd;
        it.data_byte = value;
        pending_items.push_back(it);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        v = lfurb_pkg::BYTE_CR;
        while (v == lfurb_pkg::BYTE_NUL || v == lfurb_pkg::BYTE_LF || v == lfurb_pkg::BYTE_CR)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic add_line(int len);
        int i;
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
                add_item(lfurb_pkg::CMD_RX_BYTE,
                         $urandom_range(0, 1) ? lfurb_pkg::BYTE_LF : lfurb_pkg::BYTE_NUL);
            add_item(lfurb_pkg::CMD_RX_BYTE, text_byte());
        end
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);
    endtask

    initial begin
        int i;
        int n;
        int goal;

        // get line with nothing pending, transmit ring empty
        add_item(lfurb_pkg::CMD_GET_LINE, 8'hFF);
        add_item(lfurb_pkg::CMD_TX_READY, 8'hFF);
        // dropped bytes, extremes, end of line
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_NUL);
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_LF);
        add_item(lfurb_pkg::CMD_RX_BYTE, 8'hFF);
        add_item(lfurb_pkg::CMD_RX_BYTE, 8'h01);
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h00);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h55);
        add_item(lfurb_pkg::CMD_TX_READY, 8'hAA);
        add_item(lfurb_pkg::CMD_GET_LINE, 8'h00);
        add_item(lfurb_pkg::CMD_PUSH, 8'h00);
        add_item(lfurb_pkg::CMD_PUSH, 8'hFF);
        add_item(lfurb_pkg::CMD_PUSH, 8'hAA);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h00);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h00);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h00);
        add_item(lfurb_pkg::CMD_TX_READY, 8'h00);
        // empty line, then nothing pending again
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);
        add_item(lfurb_pkg::CMD_GET_LINE, 8'h00);
        add_item(lfurb_pkg::CMD_GET_LINE, 8'h00);
        add_item(lfurb_pkg::CMD_RX_BYTE, 8'h80);
        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);

        // carriage return flood: full rings, flush with lines still counted, echo drops
        for (i = 0; i < CR_FLOOD_ITEMS; i++)
            add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);
        for (i = 0; i < TX_DEPTH + 1; i++)
            add_item(lfurb_pkg::CMD_TX_READY, 8'($urandom_range(0, 255)));

        goal = TOTAL_ITEMS;
        while (pending_items.size() < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    add_line($urandom_range(0, 8));
                    if ($urandom_range(0, 1))
                        add_item(lfurb_pkg::CMD_GET_LINE, 8'($urandom_range(0, 255)));
                end
                4: add_item(lfurb_pkg::CMD_GET_LINE, 8'($urandom_range(0, 255)));
                5, 6: begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        add_item(lfurb_pkg::CMD_TX_READY, 8'($urandom_range(0, 255)));
                end
                7: begin
                    n = ($urandom_range(0, 7) == 0) ? 35 : $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        add_item(lfurb_pkg::CMD_PUSH, 8'($urandom_range(0, 255)));
                end
                8: begin
                    n = $urandom_range(20, 40);
                    for (i = 0; i < n; i++) add_item(lfurb_pkg::CMD_RX_BYTE, text_byte());
                    if ($urandom_range(0, 1))
                        add_item(lfurb_pkg::CMD_RX_BYTE, lfurb_pkg::BYTE_CR);
                end
                default: add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            endcase
        end
        total_items = pending_items.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_items != total_items) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("TIMEOUT at %0t ns", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
